>>> design/fpsa_pkg.sv
// Shared types and constants for the free page stack allocator.
`default_nettype none

package fpsa_pkg;

  localparam int FPSA_DEPTH            = 4096;
  localparam int FPSA_ENTRIES_PER_PAGE = 512;
  localparam int FPSA_PAGES_PER_TABLE  = 512;

  localparam int ADDR_W     = 64;
  localparam int PAGE_SHIFT = 12;
  localparam int PG_W       = ADDR_W - PAGE_SHIFT;
  localparam int TYPE_W     = 32;
  localparam int PUSHED_W   = 13;

  localparam logic [ADDR_W-1:0]     LOW_MEM_LIMIT = 64'h0000_0000_000F_FFFF;
  localparam logic [PAGE_SHIFT-1:0] PAGE_OFFSET_ZERO = '0;
  localparam logic [TYPE_W-1:0]     TYPE_USABLE   = 32'd1;
  localparam logic [1:0]            ATTR_ENABLED  = 2'b01;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [1:0] {
    FN_ADD_REGION = 2'd0,
    FN_ALLOC      = 2'd1,
    FN_FREE       = 2'd2,
    FN_NONE       = 2'd3
  } func_t;

  typedef struct packed {
    func_t             func;
    logic              region_ok;
    logic [PG_W:0]     first_pg;
    logic [PG_W-1:0]   end_pg;
    logic [ADDR_W-1:0] freed_addr;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   alloc_addr;
    logic [PUSHED_W-1:0] pages_pushed;
    logic                overflow;
  } result_t;

endpackage

`default_nettype wire

>>> design/fpsa_front.sv
// Front end: accepts input transactions and classifies them into commands.
`default_nettype none

module fpsa_front import fpsa_pkg::*; (
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_func,
  input  wire logic [ADDR_W-1:0] in_region_base,
  input  wire logic [ADDR_W-1:0] in_region_len,
  input  wire logic [TYPE_W-1:0] in_region_type,
  input  wire logic [TYPE_W-1:0] in_region_attrs,
  input  wire logic [ADDR_W-1:0] in_freed_addr,
  input  wire logic              q_full,
  output logic                   q_push,
  output cmd_t                   q_cmd
);

  logic [PG_W:0]     first_pg;
  logic [ADDR_W-1:0] end_byte;
  logic [PG_W-1:0]   end_pg;
  logic              usable;

  always_comb begin
    first_pg = {1'b0, in_region_base[ADDR_W-1:PAGE_SHIFT]}
             + {{PG_W{1'b0}}, (in_region_base[PAGE_SHIFT-1:0] != PAGE_OFFSET_ZERO)};
    end_byte = in_region_base + in_region_len;
    end_pg   = end_byte[ADDR_W-1:PAGE_SHIFT];
    usable   = (in_region_type == TYPE_USABLE)
            && (in_region_attrs[1:0] == ATTR_ENABLED)
            && (in_region_base > LOW_MEM_LIMIT)
            && (first_pg < {1'b0, end_pg});
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.func       = func_t'(in_func);
    q_cmd.region_ok  = usable;
    q_cmd.first_pg   = first_pg;
    q_cmd.end_pg     = end_pg;
    q_cmd.freed_addr = in_freed_addr;
  end

endmodule

`default_nettype wire

>>> design/fpsa_cmd_queue.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none

module fpsa_cmd_queue import fpsa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      q_valid,
  output cmd_t      q_cmd
);

  cmd_t               entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QPTR_W:0]    cnt_r;
  logic [QPTR_W-1:0]  wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_nxt;
  logic [QPTR_W:0]    cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> design/fpsa_back.sv
// Back end: executes commands against the page stack and registers results.
`default_nettype none

module fpsa_back import fpsa_pkg::*; #(
  parameter int DEPTH            = FPSA_DEPTH,
  parameter int ENTRIES_PER_PAGE = FPSA_ENTRIES_PER_PAGE,
  parameter int PAGES_PER_TABLE  = FPSA_PAGES_PER_TABLE
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  input  wire logic out_stall,
  output logic      out_valid,
  output result_t   out_res
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int SW   = $clog2(PAGES_PER_TABLE + 1);
  localparam int SUMW = CW + 13;
  localparam logic [CW-1:0]   DEPTH_C  = CW'(DEPTH);
  localparam logic [SUMW-1:0] DEPTH_S  = SUMW'(DEPTH);
  localparam logic [SUMW-1:0] EPP_S    = SUMW'(ENTRIES_PER_PAGE);
  localparam logic [SW-1:0]   SPT_LAST = SW'(PAGES_PER_TABLE - 1);
  localparam bit CLAMP_CLEARS = ((DEPTH / ENTRIES_PER_PAGE) % PAGES_PER_TABLE) == 0;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_READ = 3'b100
  } state_t;

  logic [ADDR_W-1:0] stack_mem [DEPTH];

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       cap_r, cap_nxt;
  logic                dir_r, dir_nxt;
  logic                tbl_r, tbl_nxt;
  logic [SW-1:0]       spt_r, spt_nxt;
  logic [PG_W-1:0]     page_r, page_nxt;
  logic [PG_W-1:0]     end_r, end_nxt;
  logic [PUSHED_W-1:0] n_r, n_nxt;
  logic [ADDR_W-1:0]   rd_data_r;
  logic                out_valid_r;
  result_t             out_res_r;

  logic              slot_free;
  logic              emit;
  result_t           emit_res;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [ADDR_W-1:0] mem_wd;
  logic              mem_re;
  logic [AW-1:0]     mem_ra;
  logic [SUMW-1:0]   cap_sum;
  logic              cap_clamp;
  logic              spt_wrap;
  logic [CW-1:0]     count_dec;

  assign slot_free = !out_valid_r || !out_stall;
  assign cap_sum   = SUMW'(cap_r) + EPP_S;
  assign cap_clamp = cap_sum > DEPTH_S;
  assign spt_wrap  = (spt_r == SPT_LAST);
  assign count_dec = count_r - CW'(1);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cap_nxt   = cap_r;
    dir_nxt   = dir_r;
    tbl_nxt   = tbl_r;
    spt_nxt   = spt_r;
    page_nxt  = page_r;
    end_nxt   = end_r;
    n_nxt     = n_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_res  = '0;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = '0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          case (q_cmd.func)
            FN_ADD_REGION: begin
              if (q_cmd.region_ok) begin
                if (!dir_r) begin
                  dir_nxt  = 1'b1;
                  page_nxt = q_cmd.first_pg[PG_W-1:0] + PG_W'(1);
                end else begin
                  page_nxt = q_cmd.first_pg[PG_W-1:0];
                end
                end_nxt   = q_cmd.end_pg;
                n_nxt     = '0;
                state_nxt = ST_WALK;
              end else begin
                emit = 1'b1;
              end
            end
            FN_ALLOC: begin
              if (count_r != '0) begin
                count_nxt = count_dec;
                mem_re    = 1'b1;
                mem_ra    = count_dec[AW-1:0];
                state_nxt = ST_READ;
              end else begin
                emit = 1'b1;
              end
            end
            FN_FREE: begin
              emit = 1'b1;
              if (count_r < cap_r && count_r < DEPTH_C) begin
                mem_we    = 1'b1;
                mem_wa    = count_r[AW-1:0];
                mem_wd    = q_cmd.freed_addr;
                count_nxt = count_r + CW'(1);
              end else begin
                emit_res.overflow = 1'b1;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (page_r >= end_r) begin
          if (slot_free) begin
            emit                  = 1'b1;
            emit_res.pages_pushed = n_r;
            state_nxt             = ST_IDLE;
          end
        end else if (count_r >= cap_r) begin
          if (cap_r >= DEPTH_C) begin
            if (slot_free) begin
              emit                  = 1'b1;
              emit_res.pages_pushed = n_r;
              emit_res.overflow     = 1'b1;
              state_nxt             = ST_IDLE;
            end
          end else begin
            if (!tbl_r) begin
              tbl_nxt = 1'b1;
            end else if (cap_clamp) begin
              cap_nxt = DEPTH_C;
              if (CLAMP_CLEARS) begin
                tbl_nxt = 1'b0;
              end
            end else begin
              cap_nxt = cap_sum[CW-1:0];
              spt_nxt = spt_wrap ? '0 : spt_r + SW'(1);
              if (spt_wrap) begin
                tbl_nxt = 1'b0;
              end
            end
            page_nxt = page_r + PG_W'(1);
          end
        end else begin
          mem_we    = 1'b1;
          mem_wa    = count_r[AW-1:0];
          mem_wd    = {page_r, PAGE_OFFSET_ZERO};
          count_nxt = count_r + CW'(1);
          n_nxt     = n_r + PUSHED_W'(1);
          page_nxt  = page_r + PG_W'(1);
        end
      end
      ST_READ: begin
        if (slot_free) begin
          emit                = 1'b1;
          emit_res.alloc_addr = rd_data_r;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= '0;
      dir_r       <= 1'b0;
      tbl_r       <= 1'b0;
      spt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
      dir_r   <= dir_nxt;
      tbl_r   <= tbl_nxt;
      spt_r   <= spt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    end_r  <= end_nxt;
    n_r    <= n_nxt;
    if (emit) begin
      out_res_r <= emit_res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= stack_mem[mem_ra];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

>>> design/free_page_stack_allocator_top.sv
// Top level of the free page stack allocator.
// The allocator keeps a stack of free page addresses in a single-port memory
// that is not cleared after reset. A front end classifies each transaction and
// places it in a two-entry command queue, and a back end carries it out and
// holds the result in an output register, so the input side keeps accepting
// while a result waits until the queue is full. In the back end a free, an
// unknown function or a rejected region is handled straight from idle, an
// allocate pops the stack and then does a registered memory read, and an
// accepted region is dispatched, walks each page it handles (pushed, or taken
// as a table or stack page) and then reports; that page walk through the stack
// memory write port sets the rate.
`default_nettype none

module free_page_stack_allocator_top import fpsa_pkg::*; #(
  parameter int DEPTH            = FPSA_DEPTH,
  parameter int ENTRIES_PER_PAGE = FPSA_ENTRIES_PER_PAGE,
  parameter int PAGES_PER_TABLE  = FPSA_PAGES_PER_TABLE
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_func,
  input  wire logic [ADDR_W-1:0]   in_region_base,
  input  wire logic [ADDR_W-1:0]   in_region_len,
  input  wire logic [TYPE_W-1:0]   in_region_type,
  input  wire logic [TYPE_W-1:0]   in_region_attrs,
  input  wire logic [ADDR_W-1:0]   in_freed_addr,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [ADDR_W-1:0]        out_alloc_addr,
  output logic [PUSHED_W-1:0]      out_pages_pushed,
  output logic                     out_overflow
);

  logic    q_full;
  logic    q_push;
  cmd_t    push_cmd;
  logic    q_pop;
  logic    q_valid;
  cmd_t    q_cmd;
  result_t res;

  fpsa_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_region_base  (in_region_base),
    .in_region_len   (in_region_len),
    .in_region_type  (in_region_type),
    .in_region_attrs (in_region_attrs),
    .in_freed_addr   (in_freed_addr),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  fpsa_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  fpsa_back #(
    .DEPTH            (DEPTH),
    .ENTRIES_PER_PAGE (ENTRIES_PER_PAGE),
    .PAGES_PER_TABLE  (PAGES_PER_TABLE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_alloc_addr   = res.alloc_addr;
  assign out_pages_pushed = res.pages_pushed;
  assign out_overflow     = res.overflow;

endmodule

`default_nettype wire

>>> design/fpsa_checker.sv
// Port checker for the free page stack allocator and its bind statement.
`default_nettype none

module fpsa_checker import fpsa_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [ADDR_W-1:0]   out_alloc_addr,
  input wire logic [PUSHED_W-1:0] out_pages_pushed,
  input wire logic                out_overflow
);

  // A result transaction is never offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result withdrawn");

  // A region result never carries a popped address.
  a_region_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pages_pushed != '0) |-> (out_alloc_addr == '0))
    else $error("region result carries an address");

  // A successful pop never reports a dropped page.
  a_pop_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_alloc_addr != '0) |-> !out_overflow)
    else $error("allocate result flags overflow");

endmodule

bind free_page_stack_allocator_top fpsa_checker u_fpsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_alloc_addr   (out_alloc_addr),
  .out_pages_pushed (out_pages_pushed),
  .out_overflow     (out_overflow)
);

`default_nettype wire

>>> bench/tb_free_page_stack_allocator_top.sv
// Self-checking testbench for the free page stack allocator top level.
`timescale 1ns / 100ps

module tb_free_page_stack_allocator_top;
  import fpsa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_ITEMS = 920;

  typedef struct packed {
    func_t             func;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
    logic [TYPE_W-1:0] rtype;
    logic [TYPE_W-1:0] attrs;
    logic [ADDR_W-1:0] freed;
  } txn_t;

  typedef struct packed {
    txn_t    txn;
    logic    typed;
    result_t known;
  } row_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_func = FN_NONE;
  logic [ADDR_W-1:0]   in_region_base = '0;
  logic [ADDR_W-1:0]   in_region_len = '0;
  logic [TYPE_W-1:0]   in_region_type = '0;
  logic [TYPE_W-1:0]   in_region_attrs = '0;
  logic [ADDR_W-1:0]   in_freed_addr = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ADDR_W-1:0]   out_alloc_addr;
  logic [PUSHED_W-1:0] out_pages_pushed;
  logic                out_overflow;

  result_t           pending_results[$];
  int unsigned       err_cnt = 0;
  int unsigned       cycle_cnt = 0;
  int unsigned       burst_left = 1;

  logic [ADDR_W-1:0] page_mem [FPSA_DEPTH];
  int unsigned       stk_count = 0;
  int unsigned       stk_cap = 0;
  bit                dir_taken = 1'b0;
  bit                tbl_present = 1'b0;

  // Rows marked typed carry hand-computed results; the others rely on the predictor.
  row_t directed_rows [0:24] = '{
    '{'{FN_ALLOC, 64'h0, 64'h0, 32'h0, 32'h0, 64'h0}, 1'b1, '{64'h0, 13'd0, 1'b0}},
    '{'{FN_FREE, 64'h0, 64'h0, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_F000}, 1'b1,
      '{64'h0, 13'd0, 1'b1}},
    '{'{FN_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, '{64'h0, 13'd0, 1'b0}},
    '{'{FN_ADD_REGION, 64'h20_0000, 64'h1_0000, 32'd2, 32'd1, 64'h0}, 1'b1,
      '{64'h0, 13'd0, 1'b0}},
    '{'{FN_ADD_REGION, 64'h20_0000, 64'h1_0000, 32'd1, 32'd3, 64'h0}, 1'b1,
      '{64'h0, 13'd0, 1'b0}},
    '{'{FN_ADD_REGION, 64'h20_0000, 64'h1_0000, 32'd1, 32'd0, 64'h0}, 1'b1,
      '{64'h0, 13'd0, 1'b0}},
    '{'{FN_ADD_REGION, 64'hF_FFFF, 64'h10_0000, 32'd1, 32'd1, 64'h0}, 1'b1,
      '{64'h0, 13'd0, 1'b0}},
    '{'{FN_ADD_REGION, 64'hFFFF_FFFF_FFFF_F001, 64'h2000, 32'd1, 32'd1, 64'h0}, 1'b1,
      '{64'h0, 13'd0, 1'b0}},
    '{'{FN_ADD_REGION, 64'h10_0800, 64'h800, 32'd1, 32'd1, 64'h0}, 1'b1,
      '{64'h0, 13'd0, 1'b0}},
    '{'{FN_ADD_REGION, 64'h10_0000, 64'h3000, 32'd1, 32'hFFFF_FFFD, 64'h0}, 1'b1,
      '{64'h0, 13'd0, 1'b0}},
    '{'{FN_ADD_REGION, 64'h20_0000, 64'h2000, 32'd1, 32'd1, 64'h0}, 1'b1,
      '{64'h0, 13'd2, 1'b0}},
    '{'{FN_ALLOC, 64'h0, 64'h0, 32'h0, 32'h0, 64'h0}, 1'b1, '{64'h20_1000, 13'd0, 1'b0}},
    '{'{FN_FREE, 64'h0, 64'h0, 32'h0, 32'h0, 64'h0}, 1'b1, '{64'h0, 13'd0, 1'b0}},
    '{'{FN_ALLOC, 64'h0, 64'h0, 32'h0, 32'h0, 64'h0}, 1'b0, '{64'h0, 13'd0, 1'b0}},
    '{'{FN_FREE, 64'h0, 64'h0, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
      '{64'h0, 13'd0, 1'b0}},
    '{'{FN_ALLOC, 64'h0, 64'h0, 32'h0, 32'h0, 64'h0}, 1'b1,
      '{64'hFFFF_FFFF_FFFF_FFFF, 13'd0, 1'b0}},
    '{'{FN_ALLOC, 64'h0, 64'h0, 32'h0, 32'h0, 64'h0}, 1'b1, '{64'h20_0000, 13'd0, 1'b0}},
    '{'{FN_ALLOC, 64'h0, 64'h0, 32'h0, 32'h0, 64'h0}, 1'b1, '{64'h0, 13'd0, 1'b0}},
    '{'{FN_ADD_REGION, 64'hFFFF_FFFF_FFFF_E000, 64'h2000, 32'd1, 32'd1, 64'h0}, 1'b0,
      '{64'h0, 13'd0, 1'b0}},
    '{'{FN_ADD_REGION, 64'h7FFF_FFFF_F123, 64'h5000, 32'd1, 32'd5, 64'h0}, 1'b0,
      '{64'h0, 13'd0, 1'b0}},
    '{'{FN_NONE, 64'h0, 64'h0, 32'h0, 32'h0, 64'h0}, 1'b1, '{64'h0, 13'd0, 1'b0}},
    '{'{FN_ADD_REGION, 64'h40_0000, 64'h4000, 32'hFFFF_FFFF, 32'd1, 64'h0}, 1'b1,
      '{64'h0, 13'd0, 1'b0}},
    '{'{FN_ADD_REGION, 64'h10_0000, 64'h0, 32'd1, 32'd1, 64'h0}, 1'b1,
      '{64'h0, 13'd0, 1'b0}},
    '{'{FN_FREE, 64'h0, 64'h0, 32'h0, 32'h0, 64'h1234_5000}, 1'b0, '{64'h0, 13'd0, 1'b0}},
    '{'{FN_ALLOC, 64'h0, 64'h0, 32'h0, 32'h0, 64'h0}, 1'b0, '{64'h0, 13'd0, 1'b0}}
  };

  // A huge region at the end fills the stack to its ceiling and overflows.
  txn_t closing_txns [0:3] = '{
    '{FN_ADD_REGION, 64'h100_0000_0000, 64'h100_0000_0000, 32'd1, 32'd1, 64'h0},
    '{FN_FREE, 64'h0, 64'h0, 32'h0, 32'h0, 64'hABCD_E000},
    '{FN_ALLOC, 64'h0, 64'h0, 32'h0, 32'h0, 64'h0},
    '{FN_ALLOC, 64'h0, 64'h0, 32'h0, 32'h0, 64'h0}
  };

  free_page_stack_allocator_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_region_base   (in_region_base),
    .in_region_len    (in_region_len),
    .in_region_type   (in_region_type),
    .in_region_attrs  (in_region_attrs),
    .in_freed_addr    (in_freed_addr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_alloc_addr   (out_alloc_addr),
    .out_pages_pushed (out_pages_pushed),
    .out_overflow     (out_overflow)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic result_t apply_txn(input txn_t t);
    result_t     r;
    logic [63:0] first_pg;
    logic [63:0] end_pg;
    logic [63:0] pg;
    int unsigned n;
    r = '0;
    n = 0;
    case (t.func)
      FN_ADD_REGION: begin
        if (t.rtype == TYPE_USABLE && t.attrs[1:0] == ATTR_ENABLED &&
            t.base > LOW_MEM_LIMIT) begin
          first_pg = (t.base >> PAGE_SHIFT) +
                     64'((t.base[PAGE_SHIFT-1:0] != PAGE_OFFSET_ZERO) ? 1 : 0);
          end_pg = (t.base + t.len) >> PAGE_SHIFT;
          if (first_pg < end_pg) begin
            if (!dir_taken) begin
              dir_taken = 1'b1;
              first_pg++;
            end
            for (pg = first_pg; pg < end_pg; pg++) begin
              if (stk_count >= stk_cap) begin
                if (stk_cap >= FPSA_DEPTH) begin
                  r.overflow = 1'b1;
                  break;
                end
                if (!tbl_present) begin
                  tbl_present = 1'b1;
                end else begin
                  stk_cap = (stk_cap + FPSA_ENTRIES_PER_PAGE > FPSA_DEPTH) ?
                            FPSA_DEPTH : stk_cap + FPSA_ENTRIES_PER_PAGE;
                  if ((stk_cap / FPSA_ENTRIES_PER_PAGE) % FPSA_PAGES_PER_TABLE == 0)
                    tbl_present = 1'b0;
                end
              end else begin
                page_mem[stk_count] = pg << PAGE_SHIFT;
                stk_count++;
                n++;
              end
            end
          end
        end
        r.pages_pushed = n[PUSHED_W-1:0];
      end
      FN_ALLOC: begin
        if (stk_count > 0) begin
          stk_count--;
          r.alloc_addr = page_mem[stk_count];
        end
      end
      FN_FREE: begin
        if (stk_count < stk_cap && stk_count < FPSA_DEPTH) begin
          page_mem[stk_count] = t.freed;
          stk_count++;
        end else begin
          r.overflow = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic txn_t make_random_txn(input int unsigned idx);
    txn_t        t;
    int unsigned pick;
    t.func = FN_NONE;
    t.base = {$urandom, $urandom};
    t.len = {$urandom, $urandom};
    t.rtype = $urandom;
    t.attrs = $urandom;
    t.freed = {$urandom, $urandom};
    if ($urandom_range(0, 1) != 0)
      t.freed[PAGE_SHIFT-1:0] = '0;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      t.func = FN_NONE;
    end else if (pick < ((idx < 300) ? 53 : 38)) begin
      t.func = FN_ALLOC;
    end else if (pick < ((idx < 300) ? 73 : 60)) begin
      t.func = FN_FREE;
    end else begin
      t.func = FN_ADD_REGION;
      t.rtype = TYPE_USABLE;
      t.attrs[1:0] = ATTR_ENABLED;
      case ($urandom_range(0, 3))
        0, 1: t.base[63:32] = '0;
        2: t.base[63:32] = '1;
        default: ;
      endcase
      if ($urandom_range(0, 1) != 0)
        t.base[PAGE_SHIFT-1:0] = '0;
      if (t.base <= LOW_MEM_LIMIT)
        t.base[20] = 1'b1;
      if ($urandom_range(0, 49) != 0)
        t.len = (64'($urandom_range(0, 48)) << PAGE_SHIFT) + 64'($urandom_range(0, 4095));
      case ($urandom_range(0, 7))
        0: begin
          t.rtype = $urandom;
          if (t.rtype == TYPE_USABLE)
            t.rtype = '0;
        end
        1: begin
          t.attrs[1:0] = 2'($urandom_range(2, 4));
        end
        2: begin
          t.base = 64'($urandom_range(0, 32'h000F_FFFF));
        end
        default: ;
      endcase
    end
    return t;
  endfunction

  task automatic drive_txn(input txn_t t, input bit typed, input result_t known);
    result_t predicted;
    int unsigned gap;
    in_valid <= 1'b1;
    in_func <= t.func;
    in_region_base <= t.base;
    in_region_len <= t.len;
    in_region_type <= t.rtype;
    in_region_attrs <= t.attrs;
    in_freed_addr <= t.freed;
    do @(posedge clk); while (in_stall);
    predicted = apply_txn(t);
    pending_results.push_back(typed ? known : predicted);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin : result_monitor
    result_t want;
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: alloc_addr %h pages_pushed %0d overflow %b",
               out_alloc_addr, out_pages_pushed, out_overflow);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_alloc_addr !== want.alloc_addr) begin
          $error("alloc_addr: expected %h, actual %h", want.alloc_addr, out_alloc_addr);
          err_cnt++;
        end
        if (out_pages_pushed !== want.pages_pushed) begin
          $error("pages_pushed: expected %0d, actual %0d", want.pages_pushed,
                 out_pages_pushed);
          err_cnt++;
        end
        if (out_overflow !== want.overflow) begin
          $error("overflow: expected %b, actual %b", want.overflow, out_overflow);
          err_cnt++;
        end
      end
    end
    case (cycle_cnt[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cycle_cnt[3:0] < 4'd5);
    endcase
  end

  initial begin : stimulus
    txn_t        t;
    int unsigned idx;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i])
      drive_txn(directed_rows[i].txn, directed_rows[i].typed, directed_rows[i].known);
    idx = 0;
    while (idx < RANDOM_ITEMS) begin
      t = make_random_txn(idx);
      drive_txn(t, 1'b0, '0);
      idx++;
    end
    foreach (closing_txns[i])
      drive_txn(closing_txns[i], 1'b0, '0);
    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
